### rtl/lens_phase_pixel_generator_assert.svh
// assertion macros used by the lens phase pixel generator top level
`ifndef LENS_PHASE_PIXEL_GENERATOR_ASSERT_SVH
`define LENS_PHASE_PIXEL_GENERATOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define LPG_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lpg assertion failed");
// next-cycle implication, disabled in reset
`define LPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lpg assertion failed");
`else
`define LPG_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define LPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/lpg_pkg.sv
// shared types, constants and tables of the lens phase pixel generator
`default_nettype none
package lpg_pkg;

  // dimensions and formats
  localparam int MAX_DIM      = 4096;
  localparam int DIM_W        = 13;
  localparam int IDX_W        = 12;
  localparam int OFS_W        = 14;
  localparam int SQ_W         = 26;
  localparam int PH_W         = 32;
  localparam int RW_W         = 24;
  localparam int RP_W         = RW_W + SQ_W;
  localparam int RAD_W        = RP_W + 1;
  localparam int LIM_W        = 48;
  localparam int CW           = 44;
  localparam int CORDIC_FRAC  = 40;
  localparam int CORDIC_STEPS = 31;
  localparam int OUT_FRAC     = 14;
  localparam int OUT_W        = 16;
  localparam int OUT_ONE      = 1 << OUT_FRAC;
  localparam int ROUND_SH     = CORDIC_FRAC - OUT_FRAC;
  localparam int RND_W        = CW - ROUND_SH;
  localparam int STEP_IDX_W   = 5;
  localparam int ADDR_W       = 6;
  localparam int DATA_W       = 64;

  localparam logic signed [CW-1:0] CORDIC_X0 = 44'sd667681663043;

  // register indexes
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_PHASE_WEIGHT_X  = 3'd2,
    REG_PHASE_WEIGHT_Y  = 3'd3,
    REG_RADIUS_WEIGHT_X = 3'd4,
    REG_RADIUS_WEIGHT_Y = 3'd5,
    REG_APERTURE_LIMIT  = 3'd6,
    REG_APERTURE_ENABLE = 3'd7
  } reg_idx_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]       image_width;
    logic [DIM_W-1:0]       image_height;
    logic signed [PH_W-1:0] phase_weight_x;
    logic signed [PH_W-1:0] phase_weight_y;
    logic [RW_W-1:0]        radius_weight_x;
    logic [RW_W-1:0]        radius_weight_y;
    logic [LIM_W-1:0]       aperture_limit;
    logic                   aperture_enable;
  } cfg_t;

  // per-request flags carried alongside the rotation
  typedef struct packed {
    logic fold;
    logic in_ap;
  } side_t;

  // arctangent of 2^-i in 2^-32 turns
  function automatic logic [PH_W-1:0] atan_turn(input logic [STEP_IDX_W-1:0] idx);
    logic [PH_W-1:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### rtl/lens_phase_pixel_generator.sv
// Lens phase pixel generator: one cos/sin sample of exp(i*(Kx*u^2+Ky*v^2)) per request.
// Pipeline: each request passes 5 front stages, 31 cordic stages and the output register.
// Throughput: one request per cycle; the whole pipeline holds only while the skid register is full.
// Reset: synchronous active-low rst_n clears all valids and loads register defaults.
`default_nettype none
`include "lens_phase_pixel_generator_assert.svh"
module lens_phase_pixel_generator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lpg_pkg::IDX_W-1:0]   in_column,
  input  wire logic [lpg_pkg::IDX_W-1:0]   in_row,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [lpg_pkg::OUT_W-1:0] out_real_part,
  output logic signed [lpg_pkg::OUT_W-1:0] out_imag_part,
  output logic                             out_inside_aperture,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lpg_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lpg_pkg::DATA_W-1:0]  pwdata,
  output logic      [lpg_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int RW = lpg_pkg::RND_W;
  localparam logic signed [lpg_pkg::CW-1:0] ROUND_HALF =
    lpg_pkg::CW'(64'd1 << (lpg_pkg::ROUND_SH - 1));
  localparam logic signed [RW-1:0] SAT_HI = RW'(lpg_pkg::OUT_ONE);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI;

  lpg_pkg::cfg_t  cfg;
  logic           pipe_en;
  logic           f_valid;
  logic [lpg_pkg::PH_W-1:0] f_z;
  lpg_pkg::side_t f_side;
  logic           c_valid;
  logic signed [lpg_pkg::CW-1:0] c_x, c_y;
  lpg_pkg::side_t c_side;

  logic signed [lpg_pkg::OUT_W-1:0] re_nxt, im_nxt;
  logic                             masked;

  logic                             out_valid_r;
  logic signed [lpg_pkg::OUT_W-1:0] out_re_r, out_im_r;
  logic                             out_in_r;
  logic                             skid_valid_r;
  logic signed [lpg_pkg::OUT_W-1:0] skid_re_r, skid_im_r;
  logic                             skid_in_r;
  logic                             out_take;

  // round to output lsb, saturate to +-1.0, undo the fold
  function automatic logic signed [RW-1:0] round_sat(
    input logic signed [lpg_pkg::CW-1:0] v,
    input logic                          neg
  );
    logic signed [lpg_pkg::CW-1:0] b;
    logic signed [RW-1:0]          r;
    b = v + ROUND_HALF;
    r = b[lpg_pkg::CW-1:lpg_pkg::ROUND_SH];
    if (r > SAT_HI) begin
      r = SAT_HI;
    end
    if (r < SAT_LO) begin
      r = SAT_LO;
    end
    if (neg) begin
      r = -r;
    end
    return r;
  endfunction

  lpg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_valid),
    .in_column (in_column),
    .in_row    (in_row),
    .cfg       (cfg),
    .out_valid (f_valid),
    .out_z     (f_z),
    .out_side  (f_side)
  );

  lpg_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (f_valid),
    .in_z      (f_z),
    .in_side   (f_side),
    .out_valid (c_valid),
    .out_x     (c_x),
    .out_y     (c_y),
    .out_side  (c_side)
  );

  // pipeline runs whenever the skid register has room
  assign pipe_en  = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  // final value with aperture masking
  always_comb begin
    masked = cfg.aperture_enable && !c_side.in_ap;
    re_nxt = masked ? '0 : lpg_pkg::OUT_W'(round_sat(c_x, c_side.fold));
    im_nxt = masked ? '0 : lpg_pkg::OUT_W'(round_sat(c_y, c_side.fold));
  end

  // output register and skid valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (c_valid) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register and skid payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_re_r <= skid_re_r;
        out_im_r <= skid_im_r;
        out_in_r <= skid_in_r;
      end
    end else if (c_valid) begin
      if (out_valid_r && !out_take) begin
        skid_re_r <= re_nxt;
        skid_im_r <= im_nxt;
        skid_in_r <= c_side.in_ap;
      end else begin
        out_re_r <= re_nxt;
        out_im_r <= im_nxt;
        out_in_r <= c_side.in_ap;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_real_part       = out_re_r;
  assign out_imag_part       = out_im_r;
  assign out_inside_aperture = out_in_r;

  // skid only fills behind a waiting result
  `LPG_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // a full skid empties as soon as the result is taken
  `LPG_ASSERT_NEXT(a_skid_drains, clk, rst_n, skid_valid_r && !out_stall, !skid_valid_r)
  // masked pixels carry a zero value
  `LPG_ASSERT_SAME(a_mask_zero, clk, rst_n, out_valid_r && cfg.aperture_enable && !out_in_r, out_re_r == '0 && out_im_r == '0)
  // values stay within plus or minus one
  `LPG_ASSERT_SAME(a_out_range, clk, rst_n, out_valid_r, out_re_r <= 16'sd16384 && out_re_r >= -16'sd16384 && out_im_r <= 16'sd16384 && out_im_r >= -16'sd16384)

endmodule
`default_nettype wire

### rtl/lpg_cfg_regs.sv
// configuration register file behind the apb-style port
`default_nettype none
module lpg_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lpg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lpg_pkg::DATA_W-1:0] pwdata,
  output logic      [lpg_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output lpg_pkg::cfg_t                   cfg
);

  lpg_pkg::cfg_t    cfg_r;
  lpg_pkg::cfg_t    cfg_nxt;
  lpg_pkg::reg_idx_t sel;
  logic             wr_en;

  assign sel    = lpg_pkg::reg_idx_t'(paddr[lpg_pkg::ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (sel)
        lpg_pkg::REG_IMAGE_WIDTH:     cfg_nxt.image_width     = pwdata[12:0];
        lpg_pkg::REG_IMAGE_HEIGHT:    cfg_nxt.image_height    = pwdata[12:0];
        lpg_pkg::REG_PHASE_WEIGHT_X:  cfg_nxt.phase_weight_x  = pwdata[31:0];
        lpg_pkg::REG_PHASE_WEIGHT_Y:  cfg_nxt.phase_weight_y  = pwdata[31:0];
        lpg_pkg::REG_RADIUS_WEIGHT_X: cfg_nxt.radius_weight_x = pwdata[23:0];
        lpg_pkg::REG_RADIUS_WEIGHT_Y: cfg_nxt.radius_weight_y = pwdata[23:0];
        lpg_pkg::REG_APERTURE_LIMIT:  cfg_nxt.aperture_limit  = pwdata[47:0];
        lpg_pkg::REG_APERTURE_ENABLE: cfg_nxt.aperture_enable = pwdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= 13'd256;
      cfg_r.image_height    <= 13'd256;
      cfg_r.phase_weight_x  <= '0;
      cfg_r.phase_weight_y  <= '0;
      cfg_r.radius_weight_x <= 24'd1;
      cfg_r.radius_weight_y <= 24'd1;
      cfg_r.aperture_limit  <= '0;
      cfg_r.aperture_enable <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (sel)
      lpg_pkg::REG_IMAGE_WIDTH:     prdata = 64'(cfg_r.image_width);
      lpg_pkg::REG_IMAGE_HEIGHT:    prdata = 64'(cfg_r.image_height);
      lpg_pkg::REG_PHASE_WEIGHT_X:  prdata = {32'd0, cfg_r.phase_weight_x};
      lpg_pkg::REG_PHASE_WEIGHT_Y:  prdata = {32'd0, cfg_r.phase_weight_y};
      lpg_pkg::REG_RADIUS_WEIGHT_X: prdata = 64'(cfg_r.radius_weight_x);
      lpg_pkg::REG_RADIUS_WEIGHT_Y: prdata = 64'(cfg_r.radius_weight_y);
      lpg_pkg::REG_APERTURE_LIMIT:  prdata = 64'(cfg_r.aperture_limit);
      lpg_pkg::REG_APERTURE_ENABLE: prdata = 64'(cfg_r.aperture_enable);
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/lpg_front.sv
// front pipeline: centered offsets, squares, weight products, phase sum and aperture test
`default_nettype none
module lpg_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [lpg_pkg::IDX_W-1:0] in_column,
  input  wire logic [lpg_pkg::IDX_W-1:0] in_row,
  input  wire lpg_pkg::cfg_t             cfg,
  output logic                           out_valid,
  output logic      [lpg_pkg::PH_W-1:0]  out_z,
  output lpg_pkg::side_t                 out_side
);

  localparam logic [lpg_pkg::DIM_W-1:0] DIM_CAP = lpg_pkg::DIM_W'(lpg_pkg::MAX_DIM);

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // stage 1: offsets
  logic [lpg_pkg::DIM_W-1:0]        w_sat, h_sat;
  logic signed [lpg_pkg::OFS_W-1:0] u_nxt, v_nxt, u_r, v_r;
  // stage 2: squares
  logic signed [2*lpg_pkg::OFS_W-1:0] usq, vsq;
  logic [lpg_pkg::SQ_W-1:0]           usq_r, vsq_r;
  // stage 3: products
  logic [lpg_pkg::PH_W-1:0] px_nxt, py_nxt, px_r, py_r;
  logic [lpg_pkg::RP_W-1:0] rx_nxt, ry_nxt, rx_r, ry_r;
  // stage 4: sums
  logic [lpg_pkg::PH_W-1:0]  z_r;
  logic [lpg_pkg::RAD_W-1:0] rad_r;
  // stage 5: fold and compare
  logic                     fold;
  logic [lpg_pkg::PH_W-1:0] zf_r;
  lpg_pkg::side_t           side_r;

  // centered half-pixel offsets u = 2j+1-W, v = 2i+1-H
  always_comb begin
    w_sat = (cfg.image_width  > DIM_CAP) ? DIM_CAP : cfg.image_width;
    h_sat = (cfg.image_height > DIM_CAP) ? DIM_CAP : cfg.image_height;
    u_nxt = $signed({1'b0, in_column, 1'b1}) - $signed({1'b0, w_sat});
    v_nxt = $signed({1'b0, in_row, 1'b1})    - $signed({1'b0, h_sat});
  end

  assign usq = u_r * u_r;
  assign vsq = v_r * v_r;

  // phase products wrap at one turn, radius products kept whole
  always_comb begin
    px_nxt = $unsigned(cfg.phase_weight_x) * {6'd0, usq_r};
    py_nxt = $unsigned(cfg.phase_weight_y) * {6'd0, vsq_r};
    rx_nxt = {26'd0, cfg.radius_weight_x} * {24'd0, usq_r};
    ry_nxt = {26'd0, cfg.radius_weight_y} * {24'd0, vsq_r};
  end

  // fold into the quarter turn around zero
  assign fold = z_r[lpg_pkg::PH_W-1] ^ z_r[lpg_pkg::PH_W-2];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      usq_r  <= usq[lpg_pkg::SQ_W-1:0];
      vsq_r  <= vsq[lpg_pkg::SQ_W-1:0];
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      z_r    <= px_r + py_r;
      rad_r  <= {1'b0, rx_r} + {1'b0, ry_r};
      zf_r   <= fold ? (z_r + 32'h80000000) : z_r;
      side_r.fold  <= fold;
      side_r.in_ap <= rad_r <= {3'd0, cfg.aperture_limit};
    end
  end

  assign out_valid = v5_r;
  assign out_z     = zf_r;
  assign out_side  = side_r;

endmodule
`default_nettype wire

### rtl/lpg_cordic.sv
// rotation-mode cordic, one micro-rotation per pipeline stage
`default_nettype none
module lpg_cordic (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [lpg_pkg::PH_W-1:0] in_z,
  input  wire lpg_pkg::side_t           in_side,
  output logic                          out_valid,
  output logic signed [lpg_pkg::CW-1:0] out_x,
  output logic signed [lpg_pkg::CW-1:0] out_y,
  output lpg_pkg::side_t                out_side
);

  localparam int N = lpg_pkg::CORDIC_STEPS;

  logic                          v_in  [N];
  logic signed [lpg_pkg::CW-1:0] x_in  [N];
  logic signed [lpg_pkg::CW-1:0] y_in  [N];
  logic [lpg_pkg::PH_W-1:0]      z_in  [N];
  lpg_pkg::side_t                s_in  [N];
  logic signed [lpg_pkg::CW-1:0] x_nxt [N];
  logic signed [lpg_pkg::CW-1:0] y_nxt [N];
  logic [lpg_pkg::PH_W-1:0]      z_nxt [N];
  logic                          v_r   [N];
  logic signed [lpg_pkg::CW-1:0] x_r   [N];
  logic signed [lpg_pkg::CW-1:0] y_r   [N];
  logic [lpg_pkg::PH_W-1:0]      z_r   [N];
  lpg_pkg::side_t                s_r   [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    // stage input
    if (i == 0) begin : g_first
      assign v_in[i] = in_valid;
      assign x_in[i] = lpg_pkg::CORDIC_X0;
      assign y_in[i] = '0;
      assign z_in[i] = in_z;
      assign s_in[i] = in_side;
    end else begin : g_next
      assign v_in[i] = v_r[i-1];
      assign x_in[i] = x_r[i-1];
      assign y_in[i] = y_r[i-1];
      assign z_in[i] = z_r[i-1];
      assign s_in[i] = s_r[i-1];
    end

    // micro-rotation toward zero residual angle
    always_comb begin
      if (z_in[i][lpg_pkg::PH_W-1]) begin
        x_nxt[i] = x_in[i] + (y_in[i] >>> i);
        y_nxt[i] = y_in[i] - (x_in[i] >>> i);
        z_nxt[i] = z_in[i] + lpg_pkg::atan_turn(lpg_pkg::STEP_IDX_W'(i));
      end else begin
        x_nxt[i] = x_in[i] - (y_in[i] >>> i);
        y_nxt[i] = y_in[i] + (x_in[i] >>> i);
        z_nxt[i] = z_in[i] - lpg_pkg::atan_turn(lpg_pkg::STEP_IDX_W'(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
        s_r[i] <= s_in[i];
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_x     = x_r[N-1];
  assign out_y     = y_r[N-1];
  assign out_side  = s_r[N-1];

endmodule
`default_nettype wire
